>>> design/lpkv_pkg.sv
// ----------------------------------------------------------------------------
// lpkv_pkg
// shared types and constants of the linear probe key/value store
// ----------------------------------------------------------------------------
package lpkv_pkg;

    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;

    // request kinds
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_SET = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_KEY = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_CHECK,
        S_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic clr_step;
        logic mod_step;
        logic probe_first;
        logic probe_next;
        logic finish;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic key_zero;
        logic mod_done;
        logic hit;
        logic empty;
        logic probe_last;
        logic out_free;
    } stat_t;

endpackage

>>> design/lpkv_req_if.sv
// ----------------------------------------------------------------------------
// lpkv_req_if
// request channel: one get or set item per handshake
// ----------------------------------------------------------------------------
interface lpkv_req_if;
    import lpkv_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] new_value;

    modport source (output valid, output kind, output key, output new_value, input ready);
    modport sink   (input valid, input kind, input key, input new_value, output ready);
endinterface

>>> design/lpkv_rsp_if.sv
// ----------------------------------------------------------------------------
// lpkv_rsp_if
// response channel: one result item per request
// ----------------------------------------------------------------------------
interface lpkv_rsp_if;
    import lpkv_pkg::*;

    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
    logic                was_inserted;

    modport source (output valid, output read_value, output status, output was_inserted,
                    input ready);
    modport sink   (input valid, input read_value, input status, input was_inserted,
                    output ready);
endinterface

>>> design/lpkv_ctrl.sv
// ----------------------------------------------------------------------------
// lpkv_ctrl
// sequencer: clearing pass, key reduction, probe loop, result hand-off
// ----------------------------------------------------------------------------
module lpkv_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lpkv_pkg::stat_t stat,
    output lpkv_pkg::cmd_t  cmd
);
    import lpkv_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.key_zero ? S_RESULT : S_MOD;
                end
            end
            S_MOD:
            begin
                if (stat.mod_done)
                begin
                    cmd.probe_first = 1'b1;
                    state_next      = S_CHECK;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                end
            end
            S_CHECK:
            begin
                if (stat.hit || stat.empty || stat.probe_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // the clearing pass runs once after reset and never again
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_CLEAR |=> state_reg != S_CLEAR)
        else $error("clearing pass re-entered");
`endif

endmodule

>>> design/lpkv_datapath.sv
// ----------------------------------------------------------------------------
// lpkv_datapath
// key and value memories, serial key reduction, probe pointer, result register
// ----------------------------------------------------------------------------
module lpkv_datapath #(
    parameter int TABLE_SIZE = 32,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpkv_pkg::cmd_t                cmd,
    output lpkv_pkg::stat_t               stat,
    input  logic                          kind,
    input  logic [lpkv_pkg::KEY_W-1:0]    key,
    input  logic [lpkv_pkg::VALUE_W-1:0]  new_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lpkv_pkg::VALUE_W-1:0]  read_value,
    output logic [lpkv_pkg::STATUS_W-1:0] status,
    output logic                          was_inserted
);
    import lpkv_pkg::*;

    localparam int  SLOT_W  = $clog2(TABLE_SIZE);
    localparam int  KEY_IN  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int  BCNT_W  = $clog2(KEY_IN + 1);
    localparam bit  IS_POW2 = ((1 << SLOT_W) == TABLE_SIZE);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);
    localparam logic [SLOT_W-1:0] MAX_COUNT = SLOT_W'(TABLE_SIZE - 2);

    // memories
    logic [KEY_BITS-1:0]   key_mem [TABLE_SIZE];
    logic [VALUE_BITS-1:0] val_mem [TABLE_SIZE];
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  key_we;
    logic [SLOT_W-1:0]     key_waddr;
    logic [KEY_BITS-1:0]   key_wdata;
    logic                  val_we;
    logic [VALUE_BITS-1:0] val_wdata;

    // item registers
    logic                  kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] nval_reg;
    logic [KEY_IN-1:0]     kshift_reg;
    logic [BCNT_W-1:0]     bcnt_reg;
    logic [SLOT_W-1:0]     rem_reg;
    logic [SLOT_W-1:0]     rem_next;
    logic [SLOT_W:0]       rem_dbl;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_inc;
    logic [SLOT_W-1:0]     probe_cnt_reg;
    logic [SLOT_W-1:0]     clr_cnt_reg;
    logic [SLOT_W-1:0]     entry_cnt_reg;

    // result and output
    logic [VALUE_BITS-1:0] res_val_reg;
    status_t               res_status_reg;
    logic                  res_ins_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_val_reg;
    status_t               out_status_reg;
    logic                  out_ins_reg;

    logic [KEY_BITS-1:0]        key_eff;
    logic [KEY_BITS+SLOT_W-1:0] key_wide;
    logic                       hit;
    logic                       empty;
    logic                       full;
    logic                       do_insert;

    assign key_eff  = KEY_BITS'(key[KEY_IN-1:0]);
    assign key_wide = (KEY_BITS + SLOT_W)'(key_eff);

    // one remainder bit per cycle, msb first
    assign rem_dbl  = {rem_reg, kshift_reg[KEY_IN-1]};
    assign rem_next = (rem_dbl >= (SLOT_W + 1)'(TABLE_SIZE))
                    ? SLOT_W'(rem_dbl - (SLOT_W + 1)'(TABLE_SIZE))
                    : rem_dbl[SLOT_W-1:0];

    assign slot_inc = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);

    assign hit       = (rd_key_reg == key_reg);
    assign empty     = (rd_key_reg == '0);
    assign full      = !hit && (!empty || (entry_cnt_reg >= MAX_COUNT));
    assign do_insert = cmd.finish && !hit && !full;

    always_comb
    begin
        stat.clr_last   = (clr_cnt_reg == LAST_SLOT);
        stat.key_zero   = (key_eff == '0);
        stat.mod_done   = IS_POW2 || (bcnt_reg == BCNT_W'(KEY_IN));
        stat.hit        = hit;
        stat.empty      = empty;
        stat.probe_last = (probe_cnt_reg == LAST_SLOT);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        rd_addr = slot_reg;
        if (cmd.probe_first)
        begin
            rd_addr = rem_reg;
        end
        else if (cmd.probe_next)
        begin
            rd_addr = slot_inc;
        end
    end

    always_comb
    begin
        key_we    = cmd.clr_step || do_insert;
        key_waddr = cmd.clr_step ? clr_cnt_reg : slot_reg;
        key_wdata = cmd.clr_step ? '0 : key_reg;
        val_we    = do_insert || (cmd.finish && hit && (kind_reg == KIND_SET));
        val_wdata = (kind_reg == KIND_SET) ? nval_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        rd_key_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[slot_reg] <= val_wdata;
        end
        rd_val_reg <= val_mem[rd_addr];
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg   <= kind;
            key_reg    <= key_eff;
            nval_reg   <= new_value[VALUE_BITS-1:0];
            kshift_reg <= key[KEY_IN-1:0];
            rem_reg    <= IS_POW2 ? key_wide[SLOT_W-1:0] : '0;
        end
        else if (cmd.mod_step)
        begin
            kshift_reg <= {kshift_reg[KEY_IN-2:0], 1'b0};
            rem_reg    <= rem_next;
        end
        if (cmd.probe_first)
        begin
            slot_reg <= rem_reg;
        end
        else if (cmd.probe_next)
        begin
            slot_reg <= slot_inc;
        end
        if (cmd.accept)
        begin
            res_val_reg    <= '0;
            res_status_reg <= (key_eff == '0) ? ST_ZERO_KEY : ST_OK;
            res_ins_reg    <= 1'b0;
        end
        else if (cmd.finish)
        begin
            res_val_reg    <= hit ? rd_val_reg : '0;
            res_status_reg <= full ? ST_FULL : ST_OK;
            res_ins_reg    <= do_insert;
        end
        if (cmd.load_out)
        begin
            out_val_reg    <= res_val_reg;
            out_status_reg <= res_status_reg;
            out_ins_reg    <= res_ins_reg;
        end
    end

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            entry_cnt_reg <= '0;
            bcnt_reg      <= '0;
            probe_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            end
            if (do_insert)
            begin
                entry_cnt_reg <= entry_cnt_reg + SLOT_W'(1);
            end
            if (cmd.accept)
            begin
                bcnt_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                bcnt_reg <= bcnt_reg + BCNT_W'(1);
            end
            if (cmd.probe_first)
            begin
                probe_cnt_reg <= '0;
            end
            else if (cmd.probe_next)
            begin
                probe_cnt_reg <= probe_cnt_reg + SLOT_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_value   = VALUE_W'(out_val_reg);
    assign status       = out_status_reg;
    assign was_inserted = out_ins_reg;

`ifndef SYNTHESIS
    // at least two slots always stay empty
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_cnt_reg <= MAX_COUNT)
        else $error("entry count beyond bound");

    // a new key only lands in a slot that was seen empty
    a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
        key_we && !cmd.clr_step |-> rd_key_reg == '0)
        else $error("insert over an occupied slot");

    // the output register is never overwritten while its item waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");
`endif

endmodule

>>> design/linear_probe_key_value_store.sv
// ----------------------------------------------------------------------------
// linear_probe_key_value_store
// open-addressed key/value table with linear probing, get and set items
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every slot of the key
// memory and holds req.ready low meanwhile. Items are then served one at a
// time: the item is taken, then the home slot (key mod TABLE_SIZE) is worked
// out one key bit per cycle over min(KEY_BITS, 32) key bits, or taken from
// the low key bits when TABLE_SIZE is a power of two, and the first slot
// read is started. The probe loop reads one slot per cycle from the key and
// value memories through their single read port, up to TABLE_SIZE slots, and
// then the result moves into the output register, waiting while that
// register still holds a result that has not been taken. A zero key skips
// reduction and probing. The next item is taken while the previous result
// still waits in the output register.
module linear_probe_key_value_store #(
    parameter int TABLE_SIZE = 32,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    lpkv_req_if.sink    req,
    lpkv_rsp_if.source  rsp
);
    import lpkv_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    // sequencer: owns the handshake on the request side
    lpkv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    assign req.ready = in_ready;

    // memories, probe pointer, entry count and the output register
    lpkv_datapath #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .kind         (req.kind),
        .key          (req.key),
        .new_value    (req.new_value),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .read_value   (rsp.read_value),
        .status       (rsp.status),
        .was_inserted (rsp.was_inserted)
    );

endmodule
